/* sv/scmd_pkg.sv */
// ----------------------------------------------------------------------------
// scmd_pkg
// Shared constants and helpers for the segmented code message decoder.
// ----------------------------------------------------------------------------
package scmd_pkg;

	// Default longest code length
	localparam int MAX_CODE_LEN_DEF = 7;

	// Field widths
	localparam int CHAR_W   = 8;
	localparam int LEN_BITS = 3;
	localparam int ACC_W    = 7;
	localparam int IDX_W    = 8;

	// Line-break characters
	localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

	// Entries for lengths 1..max_len: sum of (2^len - 1)
	function automatic int cb_depth(input int max_len);
		return (2 << max_len) - max_len - 2;
	endfunction

endpackage

/* sv/segmented_code_message_decoder.sv */
// Timing: a result appears on the master side in the cycle after the character
//   that completes its code (or the zero length) is transferred.
// Throughput: one character per cycle unless the master side stalls; the
//   single registered codebook read lets a new character follow every cycle.
// Reset: arst_n clears the phase, length and fill state; the codebook memory
//   is not cleared, entries beyond the current fill count decode as 0.
// ----------------------------------------------------------------------------
// segmented_code_message_decoder
// Fills a codebook from header characters, then decodes bit characters into
// codebook symbols, one newline with message_end at each message end.
// ----------------------------------------------------------------------------
module segmented_code_message_decoder import scmd_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CHAR_W-1:0] s_axis_tdata,  // [7:0] in_char
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,  // [7:0] out_char
	output logic              m_axis_tuser   // [0] message_end
);

	localparam int DEPTH = cb_depth(MAX_CODE_LEN);
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);

	// Decoder state
	logic                bit_phase_q, bit_phase_d;
	logic                reading_len_q, reading_len_d;
	logic [LEN_BITS-1:0] cur_len_q, cur_len_d;
	logic [ACC_W-1:0]    acc_q, acc_d;
	logic [LEN_BITS-1:0] taken_q, taken_d;
	logic [FW-1:0]       fill_q, fill_d;

	// Result register
	logic out_valid_q, end_q, hit_q;

	// Per-character decode
	logic                accept;
	logic                brk;
	logic [ACC_W-1:0]    acc_shift;
	logic [LEN_BITS-1:0] taken_inc;
	logic [ACC_W-1:0]    code_mask;
	logic [ACC_W-1:0]    code_val;
	logic [IDX_W-1:0]    idx_base;
	logic [IDX_W-1:0]    idx;
	logic                res_valid, res_end, res_lookup, res_hit;
	logic                wr_en;
	logic [CHAR_W-1:0]   rd_data;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign brk           = (s_axis_tdata == CH_LF) || (s_axis_tdata == CH_CR);
	assign acc_shift     = {acc_q[ACC_W-2:0], s_axis_tdata[0]};
	assign taken_inc     = taken_q + LEN_BITS'(1);
	assign code_mask     = (ACC_W'(1) << cur_len_q) - ACC_W'(1);
	assign code_val      = acc_shift & code_mask;
	assign idx_base      = (IDX_W'(1) << cur_len_q) - IDX_W'(cur_len_q) - IDX_W'(1);
	assign idx           = idx_base + IDX_W'(code_val);
	assign res_hit       = (32'(cur_len_q) <= MAX_CODE_LEN) && (idx < IDX_W'(fill_q));

	// Next state for the offered character
	always_comb begin
		bit_phase_d   = bit_phase_q;
		reading_len_d = reading_len_q;
		cur_len_d     = cur_len_q;
		acc_d         = acc_q;
		taken_d       = taken_q;
		fill_d        = fill_q;
		res_valid     = 1'b0;
		res_end       = 1'b0;
		res_lookup    = 1'b0;
		wr_en         = 1'b0;
		if (!bit_phase_q) begin
			// Header: store symbols, a line break after an entry or a full codebook ends it
			if (brk) begin
				if (fill_q != '0) begin
					bit_phase_d   = 1'b1;
					reading_len_d = 1'b1;
					cur_len_d     = '0;
					acc_d         = '0;
					taken_d       = '0;
				end
			end else begin
				wr_en  = 1'b1;
				fill_d = fill_q + FW'(1);
				if (fill_d == FW'(DEPTH)) begin
					bit_phase_d   = 1'b1;
					reading_len_d = 1'b1;
					cur_len_d     = '0;
					acc_d         = '0;
					taken_d       = '0;
				end
			end
		end else if (!brk) begin
			// Bit phase: shift in the low bit of the character
			acc_d   = acc_shift;
			taken_d = taken_inc;
			if (reading_len_q) begin
				if (taken_inc == LEN_BITS'(LEN_BITS)) begin
					acc_d   = '0;
					taken_d = '0;
					if (acc_shift[LEN_BITS-1:0] == '0) begin
						bit_phase_d   = 1'b0;
						fill_d        = '0;
						reading_len_d = 1'b1;
						cur_len_d     = '0;
						res_valid     = 1'b1;
						res_end       = 1'b1;
					end else begin
						cur_len_d     = acc_shift[LEN_BITS-1:0];
						reading_len_d = 1'b0;
					end
				end
			end else if (taken_inc == cur_len_q) begin
				acc_d   = '0;
				taken_d = '0;
				if (code_val == code_mask) begin
					reading_len_d = 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_lookup = 1'b1;
				end
			end
		end
	end

	// Advance decoder state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_phase_q   <= 1'b0;
			reading_len_q <= 1'b1;
			cur_len_q     <= '0;
			acc_q         <= '0;
			taken_q       <= '0;
			fill_q        <= '0;
		end else if (accept) begin
			bit_phase_q   <= bit_phase_d;
			reading_len_q <= reading_len_d;
			cur_len_q     <= cur_len_d;
			acc_q         <= acc_d;
			taken_q       <= taken_d;
			fill_q        <= fill_d;
		end
	end

	// Codebook storage and lookup
	scmd_codebook #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_codebook (
		.clk    (clk),
		.wr_en  (accept && wr_en),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(s_axis_tdata),
		.rd_en  (accept && res_lookup),
		.rd_addr(idx[AW-1:0]),
		.rd_data(rd_data)
	);

	// Result register: load when free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			end_q <= res_end;
			hit_q <= res_hit;
		end
	end

	// Drive the master side
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = end_q;
	assign m_axis_tdata  = end_q ? CH_LF : (hit_q ? rd_data : '0);

endmodule

/* sv/scmd_codebook.sv */
// ----------------------------------------------------------------------------
// scmd_codebook
// Codebook storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scmd_codebook import scmd_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	localparam int DEPTH = cb_depth(MAX_CODE_LEN),
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	// Store header symbols
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read on demand, hold the data otherwise
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* test/scmd_checker.sv */
// ----------------------------------------------------------------------------
// scmd_checker
// Watches both streams of the segmented code message decoder. Keeps its own
// codebook and bit-phase state, predicts the decoded character for every
// character transfer and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module scmd_checker import scmd_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [CHAR_W-1:0] s_axis_tdata,  // [7:0] in_char
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [CHAR_W-1:0] m_axis_tdata,  // [7:0] out_char
	input  logic              m_axis_tuser,  // [0] message_end
	output int                errors,
	output int                pending,
	output int                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOOK_DEPTH = cb_depth(MAX_CODE_LEN);

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              message_end;
	} decoded_t;

	// Shadow of the decoder state
	logic [CHAR_W-1:0] book [0:BOOK_DEPTH-1];
	int                filled      = 0;
	logic              bit_phase   = 1'b0;
	logic              want_length = 1'b1;
	int                code_len    = 0;
	logic [ACC_W-1:0]  shift_bits  = '0;
	int                bits_in     = 0;

	decoded_t decoded_q[$];

	initial begin
		errors  = 0;
		pending <= 0;
		checked = 0;
	end

	// Leave the header and look for a length next
	task automatic begin_bits();
		bit_phase   = 1'b1;
		want_length = 1'b1;
		code_len    = 0;
		shift_bits  = '0;
		bits_in     = 0;
	endtask

	// Advance the shadow state by one character, queue any decoded character
	task automatic decode_char(input logic [CHAR_W-1:0] ch);
		logic brk;
		int   val;
		int   mask;
		int   slot;
		brk = (ch == CH_LF) || (ch == CH_CR);
		if (!bit_phase) begin
			if (brk) begin
				if (filled != 0)
					begin_bits();
			end else begin
				if (filled < BOOK_DEPTH)
					book[filled] = ch;
				filled++;
				if (filled >= BOOK_DEPTH)
					begin_bits();
			end
		end else if (!brk) begin
			shift_bits = {shift_bits[ACC_W-2:0], ch[0]};
			bits_in++;
			if (want_length) begin
				if (bits_in == LEN_BITS) begin
					val        = int'(shift_bits[LEN_BITS-1:0]);
					shift_bits = '0;
					bits_in    = 0;
					if (val == 0) begin
						bit_phase   = 1'b0;
						filled      = 0;
						want_length = 1'b1;
						code_len    = 0;
						decoded_q.push_back('{out_char: CH_LF, message_end: 1'b1});
					end else begin
						code_len    = val;
						want_length = 1'b0;
					end
				end
			end else if (bits_in == code_len) begin
				mask       = (1 << code_len) - 1;
				val        = int'(shift_bits) & mask;
				shift_bits = '0;
				bits_in    = 0;
				if (val == mask) begin
					want_length = 1'b1;
				end else begin
					// Codes past the entries of this header decode as zero
					slot = (1 << code_len) - code_len - 1 + val;
					if (slot < filled && slot < BOOK_DEPTH)
						decoded_q.push_back('{out_char: book[slot], message_end: 1'b0});
					else
						decoded_q.push_back('{out_char: '0, message_end: 1'b0});
				end
			end
		end
	endtask

	// Compare result transfers, then predict from character transfers
	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			filled      = 0;
			bit_phase   = 1'b0;
			want_length = 1'b1;
			code_len    = 0;
			shift_bits  = '0;
			bits_in     = 0;
			decoded_q.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result out_char %0d message_end %0b",
							$realtime, m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					checked++;
					if (m_axis_tdata !== want.out_char || m_axis_tuser !== want.message_end) begin
						if (errors < 10)
							$display("%0t: mismatch: expected out_char %0d message_end %0b, got %0d %0b",
								$realtime, want.out_char, want.message_end,
								m_axis_tdata, m_axis_tuser);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_char(s_axis_tdata);
			pending <= decoded_q.size();
		end
	end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives character streams into the segmented code message decoder: a short
// directed message, then random messages with well-formed bit sections, stray
// line breaks, odd bit characters and full codebooks. Both sides stall at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top import scmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN    = MAX_CODE_LEN_DEF;
	localparam int BOOK_DEPTH = cb_depth(MAX_LEN);
	localparam int NUM_CHARS  = 1200;
	localparam int CYCLE_CAP  = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata = '0;   // [7:0] in_char
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [CHAR_W-1:0] m_axis_tdata;        // [7:0] out_char
	logic              m_axis_tuser;        // [0] message_end

	int   errors;
	int   pending;
	int   checked;
	int   cycles = 0;
	int   chars_sent = 0;
	int   messages = 0;
	int   full_books = 0;
	logic no_gaps = 1'b0;
	int   ready_hold = 0;

	segmented_code_message_decoder #(.MAX_CODE_LEN(MAX_LEN)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	scmd_checker #(.MAX_CODE_LEN(MAX_LEN)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Stall the result side: long ready stretches, short and long gaps
	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				m_axis_tready <= 1'b1;
				ready_hold    <= $urandom_range(0, 20);
			end else if (r < 90) begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(5, 30);
			end
		end
	end

	// Present one character after a random gap and hold it until taken
	task automatic send_char(input logic [CHAR_W-1:0] ch);
		int r;
		int gap;
		r   = $urandom_range(0, 99);
		gap = 0;
		if (!no_gaps) begin
			if (r >= 90)
				gap = $urandom_range(5, 30);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Hold off the sender until every decoded character is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Character standing for one bit: mostly '0'/'1', sometimes any byte
	function automatic logic [CHAR_W-1:0] bit_char(input logic b);
		logic [CHAR_W-1:0] ch;
		if ($urandom_range(0, 3) != 0)
			return 8'h30 | CHAR_W'(b);
		ch = CHAR_W'($urandom_range(0, 255));
		ch[0] = b;
		if (ch == CH_LF || ch == CH_CR)
			ch = 8'h30 | CHAR_W'(b);
		return ch;
	endfunction

	// Send a value MSB first, with the odd line break in between
	task automatic send_bits(input int value, input int nbits);
		for (int i = nbits - 1; i >= 0; i--) begin
			if ($urandom_range(0, 19) == 0)
				send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
			send_char(bit_char(value[i]));
		end
	endtask

	// One message: header of the given size, coded segments, zero length
	task automatic send_message(input int header_len);
		logic [CHAR_W-1:0] ch;
		int segs;
		int len;
		int codes;
		repeat ($urandom_range(0, 2))
			send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
		for (int i = 0; i < header_len; i++) begin
			do
				ch = CHAR_W'($urandom_range(0, 255));
			while (ch == CH_LF || ch == CH_CR);
			send_char(ch);
		end
		if (header_len < BOOK_DEPTH || $urandom_range(0, 1))
			send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
		segs = $urandom_range(1, 4);
		for (int s = 0; s < segs; s++) begin
			len = $urandom_range(1, MAX_LEN);
			send_bits(len, LEN_BITS);
			codes = $urandom_range(0, 6);
			for (int c = 0; c < codes; c++)
				send_bits($urandom_range(0, (1 << len) - 2), len);
			send_bits((1 << len) - 1, len);
		end
		// Now and then break the framing with a stray bit
		if ($urandom_range(0, 11) == 0)
			send_char(bit_char($urandom_range(0, 1)));
		send_bits(0, LEN_BITS);
		messages++;
	endtask

	initial begin
		int r;
		int header_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: skipped breaks, extreme symbols, hit and unfilled codes
		send_char(CH_LF);
		send_char(CH_CR);
		send_char(8'hFF);
		send_char(8'h00);
		send_char(8'h58);
		send_char(CH_LF);
		send_char(CH_CR);
		send_bits(1, LEN_BITS);
		send_char(8'h30);
		send_char(8'h61);
		send_bits(2, LEN_BITS);
		send_bits(0, 2);
		send_bits(2, 2);
		send_bits(3, 2);
		send_bits(0, LEN_BITS);
		messages++;
		drain();

		// Random messages; the first one fills the whole codebook
		while (chars_sent < NUM_CHARS) begin
			no_gaps = ($urandom_range(0, 9) < 3);
			r = $urandom_range(0, 99);
			if (messages == 1 || r < 8)
				header_len = BOOK_DEPTH;
			else if (r < 28)
				header_len = $urandom_range(31, 130);
			else
				header_len = $urandom_range(1, 30);
			if (header_len == BOOK_DEPTH)
				full_books++;
			send_message(header_len);
			if ($urandom_range(0, 5) == 0)
				drain();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d characters in %0d messages, %0d with a full codebook",
			chars_sent, messages, full_books);
		$display("compared %0d decoded characters", checked);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending);
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/scmd_pkg.sv
sv/scmd_codebook.sv
sv/segmented_code_message_decoder.sv
test/scmd_checker.sv
test/tb_top.sv
